/* rtl/core/lfpd_pkg.sv */
// shared types, widths and constants of the line follower pid drive
package lfpd_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int GAIN_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int ERR_W       = 4;
   localparam int DIFF_W      = ERR_W + 1;
   localparam int SUM_W       = 16;
   localparam int SPEED_W     = 24;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int NUM_SENSORS = 5;

   // product and accumulation widths
   localparam int GAIN_S_W   = GAIN_W + 1;
   localparam int PROD_P_W   = GAIN_S_W + ERR_W;
   localparam int PROD_I_W   = GAIN_S_W + SUM_W;
   localparam int PROD_D_W   = GAIN_S_W + DIFF_W;
   localparam int PID_W      = PROD_I_W + 1;
   localparam int DRIVE_W    = PID_W + 1;
   localparam int SCALE_S_W  = BYTE_W + 1;
   localparam int SCALED_W   = DRIVE_W + SCALE_S_W;
   localparam int FRAC_W     = 8;
   localparam int SHIFTED_W  = SCALED_W - FRAC_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_SPEED      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_SCALE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSE_THRESHOLD = 3'd5;

   // register reset values
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd845;
   localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = 16'd102;
   localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 16'd256;
   localparam logic [BYTE_W-1:0]   BASE_SPEED_RST  = 8'd33;
   localparam logic [BYTE_W-1:0]   SPEED_SCALE_RST = 8'd102;
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RST   = 12'd2048;

   // white patterns, sample_a in the top bit
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_P4 = 5'h1E;
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_P3 = 5'h1C;
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_P2 = 5'h1D;
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_P1 = 5'h19;
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_Z  = 5'h1B;
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_N1 = 5'h13;
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_N2 = 5'h17;
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_N3 = 5'h07;
   localparam logic [NUM_SENSORS-1:0] PAT_ERR_N4 = 5'h0F;
   localparam logic [NUM_SENSORS-1:0] PAT_ALL    = 5'h1F;

   localparam logic signed [ERR_W-1:0] ERR_LOST_POS = 4'sd5;
   localparam logic signed [ERR_W-1:0] ERR_LOST_NEG = -4'sd5;
   localparam logic signed [ERR_W-1:0] ERR_LEFT_EDGE = -4'sd4;

   localparam logic signed [SUM_W:0] SUM_HI = 17'sd32767;
   localparam logic signed [SUM_W:0] SUM_LO = -17'sd32768;

   localparam logic signed [SHIFTED_W-1:0] SPEED_HI = 36'sd8388607;
   localparam logic signed [SHIFTED_W-1:0] SPEED_LO = -36'sd8388608;

   typedef struct packed {
      logic load_in;
      logic do_err;
      logic do_prod;
      logic do_pid;
      logic load_out;
   } lfpd_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ERR  = 5'b00010,
      ST_PROD = 5'b00100,
      ST_PID  = 5'b01000,
      ST_OUT  = 5'b10000
   } lfpd_state_type;

   function automatic logic signed [SPEED_W-1:0] sat_speed(
      input logic signed [SHIFTED_W-1:0] v);
      logic signed [SPEED_W-1:0] r;
      if (v > SPEED_HI) begin
         r = SPEED_HI[SPEED_W-1:0];
      end else if (v < SPEED_LO) begin
         r = SPEED_LO[SPEED_W-1:0];
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/lfpd_if.sv */
// request and response channel interfaces
interface lfpd_req_if;
   logic                          valid;
   logic                          ready;
   logic [lfpd_pkg::SAMPLE_W-1:0] sample_a;
   logic [lfpd_pkg::SAMPLE_W-1:0] sample_b;
   logic [lfpd_pkg::SAMPLE_W-1:0] sample_c;
   logic [lfpd_pkg::SAMPLE_W-1:0] sample_d;
   logic [lfpd_pkg::SAMPLE_W-1:0] sample_e;
   logic                          halt;

   modport source (output valid, sample_a, sample_b, sample_c, sample_d, sample_e, halt,
                   input ready);
   modport sink (input valid, sample_a, sample_b, sample_c, sample_d, sample_e, halt,
                 output ready);
endinterface

interface lfpd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lfpd_pkg::SPEED_W-1:0] left_speed;
   logic signed [lfpd_pkg::SPEED_W-1:0] right_speed;
   logic signed [lfpd_pkg::ERR_W-1:0]   line_error;
   logic                                pattern_hit;

   modport source (output valid, left_speed, right_speed, line_error, pattern_hit,
                   input ready);
   modport sink (input valid, left_speed, right_speed, line_error, pattern_hit,
                 output ready);
endinterface

/* rtl/core/line_follower_pid_drive_top.sv */
// line follower pid drive: five reflectance samples in, two wheel speeds out
//
// req_chan carries five 12-bit samples and a halt flag; rsp_chan carries the
// left and right wheel speeds (signed Q.8, saturated), the line error used and
// a pattern hit flag. csr_we/csr_index/csr_wdata write the gains, base speed,
// speed scale and sense threshold, one register per cycle; the user must write
// them only while idle, as the block itself does not enforce it. An item with
// halt set is taken and gives no result and leaves the loop state alone. Any
// other item gives one result through the four-step sequence decode, products,
// pid sum, scale and saturate, run once per item through the shared datapath;
// a new item is taken only when the last one reaches its last step.
// Reset loads the default gains and settings, clears last error and the
// integral, and leaves no result pending.
// The result stays in an output register until it is taken; meanwhile the next
// item is taken and computed, and waits at its last step for the register.
module line_follower_pid_drive_top (
   input  logic                                 clock,
   input  logic                                 reset,
   lfpd_req_if.sink                             req_chan,
   lfpd_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [lfpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lfpd_pkg::*;

   lfpd_cmd_type cmd;

   lfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_halt  (req_chan.halt),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   lfpd_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sample_a    (req_chan.sample_a),
      .sample_b    (req_chan.sample_b),
      .sample_c    (req_chan.sample_c),
      .sample_d    (req_chan.sample_d),
      .sample_e    (req_chan.sample_e),
      .left_speed  (rsp_chan.left_speed),
      .right_speed (rsp_chan.right_speed),
      .line_error  (rsp_chan.line_error),
      .pattern_hit (rsp_chan.pattern_hit)
   );

endmodule

/* rtl/core/lfpd_ctrl.sv */
// sequencer for the pid drive: steps each item through decode, multiply, sum and output
module lfpd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_halt,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output lfpd_pkg::lfpd_cmd_type cmd
);
   import lfpd_pkg::*;

   lfpd_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic           out_free;
   logic           start;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign start     = req_valid && !req_halt;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (start) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.do_err = 1'b1;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            cmd.do_prod = 1'b1;
            state_in    = ST_PID;
         end
         ST_PID: begin
            cmd.do_pid = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // wait here while the previous result has not been taken
            if (out_free) begin
               cmd.load_out = 1'b1;
               req_ready    = 1'b1;
               state_in     = start ? ST_ERR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.load_in = req_ready && req_valid;
   end

   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* rtl/core/lfpd_dpath.sv */
// datapath: control registers, line decode, pid terms and wheel speed scaling
module lfpd_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [lfpd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  lfpd_pkg::lfpd_cmd_type                cmd,
   input  logic [lfpd_pkg::SAMPLE_W-1:0]         sample_a,
   input  logic [lfpd_pkg::SAMPLE_W-1:0]         sample_b,
   input  logic [lfpd_pkg::SAMPLE_W-1:0]         sample_c,
   input  logic [lfpd_pkg::SAMPLE_W-1:0]         sample_d,
   input  logic [lfpd_pkg::SAMPLE_W-1:0]         sample_e,
   output logic signed [lfpd_pkg::SPEED_W-1:0]   left_speed,
   output logic signed [lfpd_pkg::SPEED_W-1:0]   right_speed,
   output logic signed [lfpd_pkg::ERR_W-1:0]     line_error,
   output logic                                  pattern_hit
);
   import lfpd_pkg::*;

   // control registers
   logic [GAIN_W-1:0]   prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [BYTE_W-1:0]   base_speed_ff, speed_scale_ff;
   logic [SAMPLE_W-1:0] threshold_ff;

   // item and loop state
   logic [SAMPLE_W-1:0]        samples_ff [NUM_SENSORS];
   logic signed [ERR_W-1:0]    last_error_ff, last_error_in;
   logic signed [SUM_W-1:0]    error_sum_ff, error_sum_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic                       hit_ff, hit_in;

   logic signed [PROD_P_W-1:0] p_prod_ff, p_prod_in;
   logic signed [PROD_I_W-1:0] i_prod_ff, i_prod_in;
   logic signed [PROD_D_W-1:0] d_prod_ff, d_prod_in;
   logic signed [DRIVE_W-1:0]  left_pre_ff, left_pre_in, right_pre_ff, right_pre_in;

   logic signed [SPEED_W-1:0]  left_ff, right_ff;
   logic signed [ERR_W-1:0]    err_out_ff;
   logic                       hit_out_ff;

   logic [NUM_SENSORS-1:0]     white, black;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [PID_W-1:0]    pid;
   logic signed [DRIVE_W-1:0]  base_q8;
   logic signed [GAIN_S_W-1:0] prop_s, integ_s, deriv_s;
   logic signed [SCALE_S_W-1:0] scale_s;
   logic signed [SCALED_W-1:0] left_scaled, right_scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= PROP_GAIN_RST;
         integ_gain_ff  <= INTEG_GAIN_RST;
         deriv_gain_ff  <= DERIV_GAIN_RST;
         base_speed_ff  <= BASE_SPEED_RST;
         speed_scale_ff <= SPEED_SCALE_RST;
         threshold_ff   <= THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROP_GAIN:       prop_gain_ff   <= csr_wdata;
            CSR_INTEG_GAIN:      integ_gain_ff  <= csr_wdata;
            CSR_DERIV_GAIN:      deriv_gain_ff  <= csr_wdata;
            CSR_BASE_SPEED:      base_speed_ff  <= csr_wdata[BYTE_W-1:0];
            CSR_SPEED_SCALE:     speed_scale_ff <= csr_wdata[BYTE_W-1:0];
            CSR_SENSE_THRESHOLD: threshold_ff   <= csr_wdata[SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // line decode and integral update
   always_comb begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
         white[NUM_SENSORS-1-i] = samples_ff[i] > threshold_ff;
         black[NUM_SENSORS-1-i] = samples_ff[i] < threshold_ff;
      end
      last_error_in = last_error_ff;
      hit_in        = 1'b1;
      // a sample equal to the threshold leaves a gap in white|black
      if ((white | black) != PAT_ALL) begin
         hit_in = 1'b0;
      end else begin
         case (white)
            PAT_ERR_P4: last_error_in = 4'sd4;
            PAT_ERR_P3: last_error_in = 4'sd3;
            PAT_ERR_P2: last_error_in = 4'sd2;
            PAT_ERR_P1: last_error_in = 4'sd1;
            PAT_ERR_Z:  last_error_in = 4'sd0;
            PAT_ERR_N1: last_error_in = -4'sd1;
            PAT_ERR_N2: last_error_in = -4'sd2;
            PAT_ERR_N3: last_error_in = -4'sd3;
            PAT_ERR_N4: last_error_in = -4'sd4;
            PAT_ALL:    last_error_in = (last_error_ff <= ERR_LEFT_EDGE) ? ERR_LOST_NEG
                                                                          : ERR_LOST_POS;
            default:    hit_in = 1'b0;
         endcase
      end
      sum_wide = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(last_error_in);
      if (sum_wide > SUM_HI) begin
         error_sum_in = SUM_HI[SUM_W-1:0];
      end else if (sum_wide < SUM_LO) begin
         error_sum_in = SUM_LO[SUM_W-1:0];
      end else begin
         error_sum_in = sum_wide[SUM_W-1:0];
      end
      diff_in = DIFF_W'(last_error_in) - DIFF_W'(last_error_ff);
   end

   // pid terms, the loop state already holds this item's error and sum
   assign prop_s    = signed'({1'b0, prop_gain_ff});
   assign integ_s   = signed'({1'b0, integ_gain_ff});
   assign deriv_s   = signed'({1'b0, deriv_gain_ff});
   assign p_prod_in = PROD_P_W'(prop_s) * PROD_P_W'(last_error_ff);
   assign i_prod_in = PROD_I_W'(integ_s) * PROD_I_W'(error_sum_ff);
   assign d_prod_in = PROD_D_W'(deriv_s) * PROD_D_W'(diff_ff);

   assign pid          = PID_W'(p_prod_ff) + PID_W'(i_prod_ff) + PID_W'(d_prod_ff);
   assign base_q8      = signed'({{(DRIVE_W-BYTE_W-FRAC_W){1'b0}}, base_speed_ff,
                                  {FRAC_W{1'b0}}});
   assign left_pre_in  = base_q8 + DRIVE_W'(pid);
   assign right_pre_in = base_q8 - DRIVE_W'(pid);

   assign scale_s      = signed'({1'b0, speed_scale_ff});
   assign left_scaled  = SCALED_W'(left_pre_ff) * SCALED_W'(scale_s);
   assign right_scaled = SCALED_W'(right_pre_ff) * SCALED_W'(scale_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (cmd.do_err) begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         samples_ff[0] <= sample_a;
         samples_ff[1] <= sample_b;
         samples_ff[2] <= sample_c;
         samples_ff[3] <= sample_d;
         samples_ff[4] <= sample_e;
      end
      if (cmd.do_err) begin
         diff_ff <= diff_in;
         hit_ff  <= hit_in;
      end
      if (cmd.do_prod) begin
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
         d_prod_ff <= d_prod_in;
      end
      if (cmd.do_pid) begin
         left_pre_ff  <= left_pre_in;
         right_pre_ff <= right_pre_in;
      end
      if (cmd.load_out) begin
         // arithmetic shift gives the floor of the division by 256
         left_ff    <= sat_speed(left_scaled[SCALED_W-1:FRAC_W]);
         right_ff   <= sat_speed(right_scaled[SCALED_W-1:FRAC_W]);
         err_out_ff <= last_error_ff;
         hit_out_ff <= hit_ff;
      end
   end

   assign left_speed  = left_ff;
   assign right_speed = right_ff;
   assign line_error  = err_out_ff;
   assign pattern_hit = hit_out_ff;

endmodule
